>>> rtl/tlvs_pkg.sv
// tlvs_pkg: types and constants shared by the element scanner files
// no dependencies; compile first

package tlvs_pkg;

  localparam int unsigned HEADER_BYTES = 6;
  localparam int unsigned ID_BYTES     = 4;
  localparam int unsigned HDR_IDX_W    = 3;
  localparam int unsigned OFS_W        = 16;
  localparam int unsigned ID_W         = 32;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CFG_DATA_W   = 32;

  localparam logic [7:0] CHAR_I = 8'h49;
  localparam logic [7:0] CHAR_U = 8'h55;

  typedef enum logic [1:0] {
    ST_FOUND      = 2'd0,
    ST_NO_MATCH   = 2'd1,
    ST_HDR_SHORT  = 2'd2,
    ST_BODY_SHORT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_DONE   = 2'd0,
    PH_HEADER = 2'd1,
    PH_SKIP   = 2'd2
  } phase_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_ID   = 1'b0,
    CFG_LIST_LENGTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    status_e           status;
    logic [OFS_W-1:0]  value;
    logic [OFS_W-1:0]  body_offset;
    logic [OFS_W-1:0]  next_offset;
  } result_t;

endpackage

>>> rtl/tlvs_if.sv
// tlvs channel interfaces: byte input, result output and register writes
// depends on tlvs_pkg

interface tlvs_in_if;
  import tlvs_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;
  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface tlvs_out_if;
  import tlvs_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [OFS_W-1:0] value;
  logic [OFS_W-1:0] body_offset;
  logic [OFS_W-1:0] next_offset;
  modport source (output valid, output status, output value, output body_offset,
                  output next_offset, input ready);
  modport sink   (input valid, input status, input value, input body_offset,
                  input next_offset, output ready);
endinterface

interface tlvs_cfg_if;
  import tlvs_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/tlv_element_scanner_top.sv
// tlv_element_scanner_top: byte-wise search of a tagged element list for an id
// depends on tlvs_pkg and the interfaces in tlvs_if.sv
//
//  channel | dir | beat contents                                    | accepted when
//  --------+-----+--------------------------------------------------+----------------
//  in_i    | in  | data_byte, first                                 | valid & ready
//  out_o   | out | status, value, body_offset, next_offset          | valid & ready
//  cfg_i   | in  | index (0 target_id, 1 list_length), data         | valid & ready
//
//  one byte is taken every cycle while in_i is not stopped (see below); a byte
//  is registered in the input stage, then the scan state and any result are
//  worked out from it once the skid slot is free; results reach out_o from the output register
//  rst_ni clears the scan to done and empties all stages at once
//  an output register plus a skid register hold results under stall, so
//  in_i only stops when both are full and a byte is waiting in the input stage

module tlv_element_scanner_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  tlvs_in_if.sink      in_i,
  tlvs_out_if.source   out_o,
  tlvs_cfg_if.sink     cfg_i
);
  import tlvs_pkg::*;

  localparam logic [HDR_IDX_W-1:0] HdrLast = HDR_IDX_W'(HEADER_BYTES);
  localparam logic [HDR_IDX_W-1:0] IdLast  = HDR_IDX_W'(ID_BYTES);
  localparam logic [OFS_W-1:0]     HdrLen  = OFS_W'(HEADER_BYTES);

  // configuration registers
  logic [ID_W-1:0]  target_q;
  logic [OFS_W-1:0] list_len_q;

  // input stage
  logic       s1_valid_q;
  logic [7:0] s1_byte_q;
  logic       s1_first_q;

  // scan state
  phase_e                phase_q, phase_d;
  logic [HDR_IDX_W-1:0]  hidx_q, hidx_d;
  logic [ID_W-1:0]       id_q, id_d;
  logic [OFS_W-1:0]      len_q, len_d;
  logic [OFS_W-1:0]      skip_q, skip_d;
  logic [OFS_W-1:0]      rem_q, rem_d;
  logic [OFS_W-1:0]      pos_q, pos_d;

  // result registers
  logic    out_valid_q;
  result_t out_q;
  logic    skid_valid_q;
  result_t skid_q;

  logic    advance;
  logic    out_take;
  logic    res_emit;
  result_t res;

  // config port never stalls
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      list_len_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_TARGET_ID:   target_q   <= cfg_i.data;
        CFG_LIST_LENGTH: list_len_q <= cfg_i.data[OFS_W-1:0];
        default: ;
      endcase
    end
  end

  // the input stage moves on whenever the skid slot is free
  assign advance    = !skid_valid_q;
  assign in_i.ready = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      s1_byte_q  <= in_i.data_byte;
      s1_first_q <= in_i.first;
    end
  end

  // one byte of scan work
  always_comb begin
    logic [OFS_W:0]   padded;
    logic [OFS_W-1:0] skip_n;
    logic [7:0]       last_ch;
    logic             is_int;

    phase_d  = phase_q;
    hidx_d   = hidx_q;
    id_d     = id_q;
    len_d    = len_q;
    skip_d   = skip_q;
    rem_d    = rem_q;
    pos_d    = pos_q;
    res_emit = 1'b0;
    res      = '{status: ST_NO_MATCH, value: '0, body_offset: '0, next_offset: '0};
    padded   = '0;
    skip_n   = '0;
    last_ch  = '0;
    is_int   = 1'b0;

    if (s1_valid_q && advance) begin
      // restart: element boundary at list start
      if (s1_first_q) begin
        pos_d  = '0;
        rem_d  = list_len_q;
        skip_d = '0;
        if (rem_d == '0) begin
          res_emit   = 1'b1;
          res.status = ST_NO_MATCH;
        end else if (rem_d < HdrLen) begin
          res_emit   = 1'b1;
          res.status = ST_HDR_SHORT;
        end else begin
          rem_d   = rem_d - HdrLen;
          hidx_d  = '0;
          id_d    = '0;
          len_d   = '0;
          phase_d = PH_HEADER;
        end
      end

      if (!res_emit) begin
        case (phase_d)
          PH_HEADER: begin
            if (hidx_d < IdLast) begin
              id_d = {id_d[ID_W-9:0], s1_byte_q};
            end else begin
              len_d = {len_d[OFS_W-9:0], s1_byte_q};
            end
            hidx_d = hidx_d + 1'b1;
            pos_d  = pos_d + 1'b1;
            if (hidx_d == HdrLast) begin
              last_ch = id_d[7:0];
              is_int  = (last_ch == CHAR_I) || (last_ch == CHAR_U);
              if (!is_int && (rem_d < len_d)) begin
                res_emit   = 1'b1;
                res.status = ST_BODY_SHORT;
              end else begin
                padded = is_int ? '0 : ({1'b0, len_d} + {{OFS_W{1'b0}}, len_d[0]});
                // pad byte past list end: clamp to what is left
                skip_n = (padded > {1'b0, rem_d}) ? rem_d : padded[OFS_W-1:0];
                if (id_d == target_q) begin
                  res_emit        = 1'b1;
                  res.status      = ST_FOUND;
                  res.value       = len_d;
                  res.body_offset = pos_d;
                  res.next_offset = pos_d + skip_n;
                end else begin
                  rem_d  = rem_d - skip_n;
                  skip_d = skip_n;
                  if (skip_n != '0) begin
                    phase_d = PH_SKIP;
                  end else if (rem_d == '0) begin
                    res_emit   = 1'b1;
                    res.status = ST_NO_MATCH;
                  end else if (rem_d < HdrLen) begin
                    res_emit   = 1'b1;
                    res.status = ST_HDR_SHORT;
                  end else begin
                    rem_d  = rem_d - HdrLen;
                    hidx_d = '0;
                    id_d   = '0;
                    len_d  = '0;
                  end
                end
              end
            end
          end
          PH_SKIP: begin
            pos_d = pos_d + 1'b1;
            if (skip_d != '0) begin
              skip_d = skip_d - 1'b1;
            end
            if (skip_d == '0) begin
              if (rem_d == '0) begin
                res_emit   = 1'b1;
                res.status = ST_NO_MATCH;
              end else if (rem_d < HdrLen) begin
                res_emit   = 1'b1;
                res.status = ST_HDR_SHORT;
              end else begin
                rem_d   = rem_d - HdrLen;
                hidx_d  = '0;
                id_d    = '0;
                len_d   = '0;
                phase_d = PH_HEADER;
              end
            end
          end
          default: ;
        endcase
      end

      // any result ends the scan
      if (res_emit) begin
        phase_d = PH_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_DONE;
      hidx_q  <= '0;
      id_q    <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      rem_q   <= '0;
      pos_q   <= '0;
    end else begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      id_q    <= id_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      rem_q   <= rem_d;
      pos_q   <= pos_d;
    end
  end

  // output register with skid slot behind it
  assign out_take = out_valid_q && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_emit) begin
      if (!out_valid_q || out_take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_emit) begin
      if (!out_valid_q || out_take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.status      = out_q.status;
  assign out_o.value       = out_q.value;
  assign out_o.body_offset = out_q.body_offset;
  assign out_o.next_offset = out_q.next_offset;

endmodule

>>> rtl/tlvs_checker.sv
// tlvs_checker: port-level assertions for the element scanner, bound to the top
// depends on tlvs_pkg and tlv_element_scanner_top

module tlvs_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [1:0]                  status_i,
  input logic [tlvs_pkg::OFS_W-1:0]  value_i,
  input logic [tlvs_pkg::OFS_W-1:0]  body_offset_i,
  input logic [tlvs_pkg::OFS_W-1:0]  next_offset_i
);
  import tlvs_pkg::*;

  localparam logic [OFS_W-1:0] HdrLen = OFS_W'(HEADER_BYTES);

  // result held until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped under stall");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(status_i) && $stable(next_offset_i))
    else $error("result changed under stall");

  // failure results carry no offsets
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i != ST_FOUND) |->
      (value_i == '0) && (body_offset_i == '0) && (next_offset_i == '0))
    else $error("non-zero fields on failure result");

  // a match sits after at least one full header and its next offset never precedes its body
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (status_i == ST_FOUND) |->
      (body_offset_i >= HdrLen) && (next_offset_i >= body_offset_i))
    else $error("found result offsets out of order");

endmodule

bind tlv_element_scanner_top tlvs_checker u_tlvs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .value_i       (out_o.value),
  .body_offset_i (out_o.body_offset),
  .next_offset_i (out_o.next_offset)
);
